// ===== rtl/can_transmit_receive_fifo_top_defines.svh =====
// Assertion macros shared by the FIFO controller and datapath.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef CAN_TRANSMIT_RECEIVE_FIFO_TOP_DEFINES_SVH
`define CAN_TRANSMIT_RECEIVE_FIFO_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTRF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CTRF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ctrf_pkg.sv =====
package ctrf_pkg;

  localparam int unsigned MaxDepth = 128;
  localparam int unsigned PosW     = $clog2(MaxDepth);
  localparam int unsigned CntW     = PosW + 1;

  localparam int unsigned OpW      = 3;
  localparam int unsigned IdW      = 29;
  localparam int unsigned LenW     = 4;
  localparam int unsigned PayW     = 64;
  localparam int unsigned HdrW     = IdW + LenW;
  localparam int unsigned FillW    = 8;
  localparam int unsigned StatW    = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 3;

  typedef enum logic [OpW-1:0] {
    OP_PUSH    = 3'd0,
    OP_PEEK    = 3'd1,
    OP_POP     = 3'd2,
    OP_TX_DONE = 3'd3,
    OP_CLEAR   = 3'd4
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_PERM  = 2'd1,
    ST_LOST  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_ENABLE    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_TX_MODE   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DEPTH_SEL = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_EVERY_MSG = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_THRESHOLD = 3'd4;

  typedef struct packed {
    logic       fifo_enable;
    logic       transmit_mode;
    logic [2:0] depth_select;
    logic       interrupt_every_message;
    logic [2:0] threshold_eighths;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic lost;
    logic rx_int;
    logic tx_int;
  } flags_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

  typedef struct packed {
    logic [StatW-1:0] status_code;
    logic [IdW-1:0]   head_identifier;
    logic [LenW-1:0]  head_length;
    logic [PayW-1:0]  head_payload;
    logic [FillW-1:0] fill_count;
    flags_t           flags;
  } res_t;

  function automatic logic [CntW-1:0] depth_of(input logic [2:0] sel);
    logic [CntW-1:0] d;
    unique case (sel)
      3'd0:    d = CntW'(0);
      3'd1:    d = CntW'(4);
      3'd2:    d = CntW'(8);
      3'd3:    d = CntW'(16);
      3'd4:    d = CntW'(32);
      3'd5:    d = CntW'(48);
      3'd6:    d = CntW'(64);
      default: d = CntW'(MaxDepth);
    endcase
    return d;
  endfunction

  // Step a position by one, wrapping at the active depth.
  function automatic logic [PosW-1:0] advance(input logic [PosW-1:0] pos,
                                              input logic [CntW-1:0] depth);
    logic [CntW-1:0] n;
    n = {1'b0, pos} + CntW'(1);
    if (n >= depth || n >= CntW'(MaxDepth)) begin
      n = '0;
    end
    return n[PosW-1:0];
  endfunction

endpackage

// ===== rtl/ctrf_if.sv =====
interface ctrf_in_if;
  import ctrf_pkg::*;
  logic              valid;
  logic              ready;
  logic [OpW-1:0]    operation;
  logic [IdW-1:0]    message_identifier;
  logic [LenW-1:0]   length_code;
  logic [PayW-1:0]   payload;

  modport source (output valid, operation, message_identifier, length_code, payload,
                  input ready);
  modport sink   (input valid, operation, message_identifier, length_code, payload,
                  output ready);
endinterface

interface ctrf_out_if;
  import ctrf_pkg::*;
  logic              valid;
  logic              ready;
  logic [StatW-1:0]  status_code;
  logic [IdW-1:0]    head_identifier;
  logic [LenW-1:0]   head_length;
  logic [PayW-1:0]   head_payload;
  logic [FillW-1:0]  fill_count;
  logic              full_flag;
  logic              empty_flag;
  logic              lost_flag;
  logic              receive_interrupt;
  logic              transmit_interrupt;

  modport source (output valid, status_code, head_identifier, head_length, head_payload,
                         fill_count, full_flag, empty_flag, lost_flag, receive_interrupt,
                         transmit_interrupt,
                  input ready);
  modport sink   (input valid, status_code, head_identifier, head_length, head_payload,
                        fill_count, full_flag, empty_flag, lost_flag, receive_interrupt,
                        transmit_interrupt,
                  output ready);
endinterface

interface ctrf_cfg_if;
  import ctrf_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/ctrf_datapath.sv =====
`include "can_transmit_receive_fifo_top_defines.svh"

module ctrf_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ctrf_pkg::cmd_t            cmd_i,
  input  logic [ctrf_pkg::OpW-1:0]  op_i,
  input  logic [ctrf_pkg::IdW-1:0]  id_i,
  input  logic [ctrf_pkg::LenW-1:0] len_i,
  input  logic [ctrf_pkg::PayW-1:0] pay_i,
  input  logic                      cfg_we_i,
  input  logic [ctrf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ctrf_pkg::CfgDataW-1:0] cfg_data_i,
  output ctrf_pkg::res_t            res_o
);
  import ctrf_pkg::*;

  // Captured word.
  logic [OpW-1:0]  op_q;
  logic [IdW-1:0]  id_q;
  logic [LenW-1:0] len_q;
  logic [PayW-1:0] pay_q;

  cfg_t            cfg_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PosW-1:0] rd_pos_q, rd_pos_d;
  logic [PosW-1:0] wr_pos_q, wr_pos_d;
  flags_t          flags_q, flags_d;
  res_t            res_q, res_d;

  // Message store: header (length code over identifier) beside the data bytes.
  logic [HdrW+PayW-1:0] mem [MaxDepth];
  logic [HdrW+PayW-1:0] rdata_q;
  logic                 mem_we;

  logic [CntW-1:0]   depth;
  logic [CntW+2:0]   thr_prod;
  logic [CntW-1:0]   rx_thr;

  assign depth    = depth_of(cfg_q.depth_select);
  assign thr_prod = (CntW+3)'(depth) * (CntW+3)'({1'b0, cfg_q.threshold_eighths} + 4'd1);
  assign rx_thr   = (cfg_q.threshold_eighths == 3'd7) ? depth : thr_prod[CntW+2:3];

  always_comb begin
    cnt_d    = cnt_q;
    rd_pos_d = rd_pos_q;
    wr_pos_d = wr_pos_q;
    flags_d  = flags_q;
    mem_we   = 1'b0;
    res_d    = '0;
    res_d.status_code = ST_OK;
    unique case (op_q)
      OP_PUSH: begin
        if (!cfg_q.fifo_enable) begin
          res_d.status_code = ST_PERM;
        end else if (cnt_q >= depth) begin
          flags_d.lost      = 1'b1;
          res_d.status_code = ST_LOST;
        end else begin
          mem_we   = 1'b1;
          cnt_d    = cnt_q + CntW'(1);
          wr_pos_d = advance(wr_pos_q, depth);
          if (cnt_d >= depth) begin
            flags_d.full = 1'b1;
          end
          flags_d.empty = 1'b0;
          if (!cfg_q.transmit_mode &&
              (cfg_q.interrupt_every_message || cnt_d >= rx_thr)) begin
            flags_d.rx_int = 1'b1;
          end
        end
      end
      OP_PEEK, OP_POP: begin
        if (!cfg_q.fifo_enable) begin
          res_d.status_code = ST_PERM;
        end else if (cnt_q == '0) begin
          res_d.status_code = ST_EMPTY;
        end else begin
          res_d.head_payload    = rdata_q[PayW-1:0];
          res_d.head_identifier = rdata_q[PayW +: IdW];
          res_d.head_length     = rdata_q[PayW+IdW +: LenW];
          if (op_q == OP_POP) begin
            cnt_d    = cnt_q - CntW'(1);
            rd_pos_d = advance(rd_pos_q, depth);
            if (cnt_d < depth) begin
              flags_d.full = 1'b0;
            end
            if (!cfg_q.transmit_mode && cnt_d == '0) begin
              flags_d.empty = 1'b1;
            end
          end
        end
      end
      OP_TX_DONE: begin
        if (cfg_q.interrupt_every_message || cnt_q == '0) begin
          flags_d.tx_int = 1'b1;
        end
        if (!cfg_q.fifo_enable) begin
          cnt_d    = '0;
          rd_pos_d = '0;
          wr_pos_d = '0;
        end
        if (cnt_d == '0) begin
          flags_d.empty = 1'b1;
        end
      end
      OP_CLEAR: begin
        cnt_d    = '0;
        rd_pos_d = '0;
        wr_pos_d = '0;
      end
      default: begin
        res_d.status_code = ST_PERM;
      end
    endcase
    res_d.fill_count = cnt_d[FillW-1:0];
    res_d.flags      = flags_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q    <= '0;
      cnt_q    <= '0;
      rd_pos_q <= '0;
      wr_pos_q <= '0;
      flags_q  <= '{full: 1'b0, empty: 1'b1, lost: 1'b0, rx_int: 1'b0, tx_int: 1'b0};
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_ENABLE:    cfg_q.fifo_enable             <= cfg_data_i[0];
          CFG_TX_MODE:   cfg_q.transmit_mode           <= cfg_data_i[0];
          CFG_DEPTH_SEL: cfg_q.depth_select            <= cfg_data_i;
          CFG_EVERY_MSG: cfg_q.interrupt_every_message <= cfg_data_i[0];
          CFG_THRESHOLD: cfg_q.threshold_eighths       <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (cmd_i.execute) begin
        cnt_q    <= cnt_d;
        rd_pos_q <= rd_pos_d;
        wr_pos_q <= wr_pos_d;
        flags_q  <= flags_d;
      end
    end
  end

  // Captured word and result register carry no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_i;
      id_q  <= id_i;
      len_q <= len_i;
      pay_q <= pay_i;
    end
    if (cmd_i.execute) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute && mem_we) begin
      mem[wr_pos_q] <= {len_q, id_q, pay_q};
    end
    rdata_q <= mem[rd_pos_q];
  end

  assign res_o = res_q;

  `CTRF_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= CntW'(MaxDepth), "fill count beyond capacity")
  `CTRF_ASSERT_NEXT(a_push_perm, cmd_i.execute && !cfg_q.fifo_enable && op_q == OP_PUSH,
    res_q.status_code == ST_PERM, "push while disabled was not refused")
  `CTRF_ASSERT_NEXT(a_clear, cmd_i.execute && op_q == OP_CLEAR,
    cnt_q == '0 && rd_pos_q == '0 && wr_pos_q == '0, "clear left state behind")

endmodule

// ===== rtl/ctrf_ctrl.sv =====
`include "can_transmit_receive_fifo_top_defines.svh"

module ctrf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ctrf_pkg::cmd_t cmd_o
);
  import ctrf_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_READ;
        end
      end
      S_READ: state_d = S_EXEC;
      S_EXEC: state_d = S_OUT;
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = (state_q == S_OUT);
  assign cmd_o.capture = in_ready_o && in_valid_i;
  assign cmd_o.execute = (state_q == S_EXEC);

  `CTRF_ASSERT_NEXT(a_capture_read, cmd_o.capture, state_q == S_READ,
    "capture not followed by the memory read cycle")
  `CTRF_ASSERT_NEXT(a_read_exec, state_q == S_READ, cmd_o.execute,
    "memory read not followed by execute")
  `CTRF_ASSERT_NEXT(a_exec_out, cmd_o.execute, out_valid_o && !in_ready_o,
    "executed word not presented")

endmodule

// ===== rtl/can_transmit_receive_fifo_top.sv =====
// CAN message FIFO with sticky status flags and interrupt requests, working in
// receive or transmit mode. Each word on req_i is one operation (push, peek,
// pop, transmit done or clear) and yields exactly one word on rsp_o with the
// status, the head message on a successful peek or pop, the fill count and the
// flags. The block handles one operation at a time: a word is taken in the
// idle state, the read state registers the memory read at the read position,
// the execute state runs the operation and loads the result register, and the
// result is offered in the output state until the sink takes it. The read
// state is there for the registered read of the message memory ahead of the
// execute step. Configuration writes on cfg_i are always ready and take
// effect at the next edge; write them only while no operation is in flight.
// The message memory has no reset and needs no clearing pass, so the block
// accepts words right after reset.
module can_transmit_receive_fifo_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  ctrf_in_if.sink           req_i,
  ctrf_out_if.source        rsp_o,
  ctrf_cfg_if.sink          cfg_i
);
  import ctrf_pkg::*;

  cmd_t cmd;
  res_t res;

  // Sequencing of capture, read, execute and result hand-off.
  ctrf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  // Registers, message memory, pointers and flag logic.
  ctrf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .op_i        (req_i.operation),
    .id_i        (req_i.message_identifier),
    .len_i       (req_i.length_code),
    .pay_i       (req_i.payload),
    .cfg_we_i    (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .res_o       (res)
  );

  // Configuration writes never stall.
  assign cfg_i.ready = 1'b1;

  assign rsp_o.status_code        = res.status_code;
  assign rsp_o.head_identifier    = res.head_identifier;
  assign rsp_o.head_length        = res.head_length;
  assign rsp_o.head_payload       = res.head_payload;
  assign rsp_o.fill_count         = res.fill_count;
  assign rsp_o.full_flag          = res.flags.full;
  assign rsp_o.empty_flag         = res.flags.empty;
  assign rsp_o.lost_flag          = res.flags.lost;
  assign rsp_o.receive_interrupt  = res.flags.rx_int;
  assign rsp_o.transmit_interrupt = res.flags.tx_int;

endmodule

// ===== tb/sv/can_transmit_receive_fifo_top_tb.sv =====
`timescale 1ns / 1ps

module can_transmit_receive_fifo_top_tb;
  import ctrf_pkg::*;

  // One operation word as it goes out on the request channel.
  typedef struct packed {
    logic [OpW-1:0]  op;
    logic [IdW-1:0]  ident;
    logic [LenW-1:0] len;
    logic [PayW-1:0] payload;
  } can_msg_t;

  // Codes 5 to 7 are not defined operations; the block must refuse them.
  localparam logic [OpW-1:0]  OP_UNDEF_FIRST = 3'd5;
  localparam logic [2:0]      DEEPEST_SEL    = 3'd7;
  localparam logic [2:0]      THRESH_FULL    = 3'd7;
  localparam logic [LenW-1:0] LEN_MAX        = 4'd8;

  localparam int unsigned DEPTH_TABLE [8] = '{0, 4, 8, 16, 32, 48, 64, MaxDepth};
  localparam logic [CfgIdxW-1:0] REG_ORDER [5] = '{CFG_ENABLE, CFG_TX_MODE, CFG_DEPTH_SEL,
                                                   CFG_EVERY_MSG, CFG_THRESHOLD};

  // The receiver stalls once for a long stretch after this many result words,
  // so that the block holds a finished result and has to refuse new requests.
  localparam int HOLD_AT     = 200;
  localparam int HOLD_LEN    = 300;
  // Cycles without any accepted word before the run is declared hung. The
  // slowest legal wait is the long receiver hold plus random gaps.
  localparam int STALL_LIMIT = 3000;

  logic clk_i = 1'b0;
  logic rst_ni;

  ctrf_in_if  req_if ();
  ctrf_out_if rsp_if ();
  ctrf_cfg_if cfg_if ();

  can_transmit_receive_fifo_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Words waiting to be sent, and the results they must produce, in order.
  can_msg_t queued_ops_q [$];
  res_t     due_results_q [$];

  int words_in    = 0;
  int words_out   = 0;
  int mismatches  = 0;
  int dead_cycles = 0;
  int hold_left   = 0;
  bit hold_done   = 1'b0;
  int settings_used = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  int full_hits   = 0;

  // During this window of request words neither side inserts any gap, so the
  // block also runs back to back for a while.
  logic no_gaps;
  assign no_gaps = (words_in >= 400) && (words_in < 480);

  // ---------------------------------------------------------------------------
  // Predictor: a private copy of the FIFO state and of the register settings.
  // It is stepped once per generated word; since registers only change while
  // the block is idle, the order of generation is the order of execution.
  // ---------------------------------------------------------------------------
  cfg_t        pred_cfg   = '0;
  flags_t      pred_flags = '{full: 1'b0, empty: 1'b1, lost: 1'b0, rx_int: 1'b0,
                              tx_int: 1'b0};
  int unsigned held   = 0;
  int unsigned rd_pos = 0;
  int unsigned wr_pos = 0;
  logic [IdW-1:0]  id_mem  [MaxDepth];
  logic [LenW-1:0] len_mem [MaxDepth];
  logic [PayW-1:0] pay_mem [MaxDepth];
  bit              written [MaxDepth];

  function automatic int unsigned next_slot(input int unsigned pos, input int unsigned depth);
    if (pos + 1 >= depth || pos + 1 >= MaxDepth) begin
      return 0;
    end
    return pos + 1;
  endfunction

  // Fill level at which a push in receive mode raises the interrupt.
  function automatic int unsigned rx_level(input int unsigned depth);
    if (pred_cfg.threshold_eighths == THRESH_FULL) begin
      return depth;
    end
    return (depth * (pred_cfg.threshold_eighths + 1)) / 8;
  endfunction

  function automatic res_t fifo_step(input can_msg_t m);
    res_t        o;
    int unsigned depth;
    o = '0;
    depth = DEPTH_TABLE[pred_cfg.depth_select];
    o.status_code = ST_OK;
    case (m.op)
      OP_PUSH: begin
        if (!pred_cfg.fifo_enable) begin
          o.status_code = ST_PERM;
        end else if (held >= depth) begin
          pred_flags.lost = 1'b1;
          o.status_code = ST_LOST;
        end else begin
          id_mem[wr_pos]  = m.ident;
          len_mem[wr_pos] = m.len;
          pay_mem[wr_pos] = m.payload;
          written[wr_pos] = 1'b1;
          held++;
          wr_pos = next_slot(wr_pos, depth);
          if (held >= depth) begin
            pred_flags.full = 1'b1;
          end
          pred_flags.empty = 1'b0;
          if (!pred_cfg.transmit_mode &&
              (pred_cfg.interrupt_every_message || held >= rx_level(depth))) begin
            pred_flags.rx_int = 1'b1;
          end
        end
      end
      OP_PEEK, OP_POP: begin
        if (!pred_cfg.fifo_enable) begin
          o.status_code = ST_PERM;
        end else if (held == 0) begin
          o.status_code = ST_EMPTY;
        end else begin
          o.head_identifier = id_mem[rd_pos];
          o.head_length     = len_mem[rd_pos];
          o.head_payload    = pay_mem[rd_pos];
          if (m.op == OP_POP) begin
            held--;
            rd_pos = next_slot(rd_pos, depth);
            if (held < depth) begin
              pred_flags.full = 1'b0;
            end
            // In transmit mode only a transmit done marks the FIFO empty.
            if (!pred_cfg.transmit_mode && held == 0) begin
              pred_flags.empty = 1'b1;
            end
          end
        end
      end
      OP_TX_DONE: begin
        if (pred_cfg.interrupt_every_message || held == 0) begin
          pred_flags.tx_int = 1'b1;
        end
        if (!pred_cfg.fifo_enable) begin
          held   = 0;
          rd_pos = 0;
          wr_pos = 0;
        end
        if (held == 0) begin
          pred_flags.empty = 1'b1;
        end
      end
      OP_CLEAR: begin
        // Clear drops the contents but leaves every flag as it was.
        held   = 0;
        rd_pos = 0;
        wr_pos = 0;
      end
      default: begin
        o.status_code = ST_PERM;
      end
    endcase
    o.fill_count = FillW'(held);
    o.flags      = pred_flags;
    return o;
  endfunction

  function automatic void queue_op(input can_msg_t m);
    res_t r;
    r = fifo_step(m);
    status_seen[r.status_code]++;
    if (m.op == OP_PUSH && r.status_code == ST_OK && r.flags.full) begin
      full_hits++;
    end
    queued_ops_q.push_back(m);
    due_results_q.push_back(r);
  endfunction

  // Random message contents, with all-zero and all-one values mixed in.
  function automatic can_msg_t msg_with(input logic [OpW-1:0] op);
    can_msg_t m;
    m.op = op;
    case ($urandom_range(7))
      0:       m.ident = '0;
      1:       m.ident = '1;
      default: m.ident = IdW'($urandom);
    endcase
    m.len = LenW'($urandom_range(8));
    case ($urandom_range(7))
      0:       m.payload = '0;
      1:       m.payload = '1;
      default: m.payload = {$urandom, $urandom};
    endcase
    return m;
  endfunction

  // Mostly pushes, pops and peeks in a ratio set per phase, so the FIFO goes
  // through full and empty; the other operations and bad codes are sprinkled in.
  function automatic can_msg_t random_op(input int push_pct);
    logic [OpW-1:0] op;
    int             pick;
    if ($urandom_range(99) < push_pct) begin
      op = OP_PUSH;
    end else begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        op = OP_POP;
      end else if (pick < 75) begin
        op = OP_PEEK;
      end else if (pick < 87) begin
        op = OP_TX_DONE;
      end else if (pick < 95) begin
        op = OP_CLEAR;
      end else begin
        op = OP_UNDEF_FIRST + OpW'($urandom_range(2));
      end
    end
    // After a depth change the head may land on a slot that never held a
    // message; that read is not defined, so a clear is sent instead.
    if ((op == OP_PEEK || op == OP_POP) && pred_cfg.fifo_enable && held != 0 &&
        !written[rd_pos]) begin
      op = OP_CLEAR;
    end
    return msg_with(op);
  endfunction

  // ---------------------------------------------------------------------------
  // Register writes and phase boundaries, run from the stimulus process.
  // ---------------------------------------------------------------------------

  // Waits until every word has been sent and answered, then lets the block
  // settle before any register changes.
  task automatic wait_idle();
    while (queued_ops_q.size() != 0 || due_results_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (6) @(posedge clk_i);
  endtask

  // Writes all five registers back to back; valid stays high across them.
  task automatic load_settings(input cfg_t s);
    logic [CfgDataW-1:0] vals [5];
    vals = '{CfgDataW'(s.fifo_enable), CfgDataW'(s.transmit_mode), s.depth_select,
             CfgDataW'(s.interrupt_every_message), s.threshold_eighths};
    for (int i = 0; i < 5; i++) begin
      cfg_if.index <= REG_ORDER[i];
      cfg_if.data  <= vals[i];
      if (i == 0) begin
        cfg_if.valid <= 1'b1;
      end
      do @(posedge clk_i); while (!cfg_if.ready);
    end
    cfg_if.valid <= 1'b0;
    pred_cfg = s;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: takes words from the queue, holds each until accepted and
  // leaves random gaps between words.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    can_msg_t nxt;
    logic     gap;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        words_in <= words_in + 1;
      end
      if (!req_if.valid || req_if.ready) begin
        gap = !no_gaps && ($urandom_range(99) < 16);
        if (queued_ops_q.size() != 0 && !gap) begin
          nxt = queued_ops_q.pop_front();
          req_if.valid              <= 1'b1;
          req_if.operation          <= nxt.op;
          req_if.message_identifier <= nxt.ident;
          req_if.length_code        <= nxt.len;
          req_if.payload            <= nxt.payload;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: checks each accepted result word against the oldest
  // prediction and drives the ready side, including the one long hold.
  // ---------------------------------------------------------------------------
  task automatic note_field(input string what, input logic [PayW-1:0] want,
                            input logic [PayW-1:0] seen);
    if (seen !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch in result word %0d, %s: expected 0x%0h, got 0x%0h",
                 words_out, what, want, seen);
      end
    end
  endtask

  always @(posedge clk_i) begin
    res_t want;
    logic stall;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        words_out <= words_out + 1;
        if (due_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result word %0d arrived with no operation outstanding", words_out);
          end
        end else begin
          want = due_results_q.pop_front();
          note_field("status", PayW'(want.status_code), PayW'(rsp_if.status_code));
          note_field("head identifier", PayW'(want.head_identifier),
                     PayW'(rsp_if.head_identifier));
          note_field("head length", PayW'(want.head_length), PayW'(rsp_if.head_length));
          note_field("head payload", want.head_payload, rsp_if.head_payload);
          note_field("fill count", PayW'(want.fill_count), PayW'(rsp_if.fill_count));
          note_field("full flag", PayW'(want.flags.full), PayW'(rsp_if.full_flag));
          note_field("empty flag", PayW'(want.flags.empty), PayW'(rsp_if.empty_flag));
          note_field("lost flag", PayW'(want.flags.lost), PayW'(rsp_if.lost_flag));
          note_field("receive interrupt", PayW'(want.flags.rx_int),
                     PayW'(rsp_if.receive_interrupt));
          note_field("transmit interrupt", PayW'(want.flags.tx_int),
                     PayW'(rsp_if.transmit_interrupt));
        end
      end
      // The long hold is counted down here; meanwhile the driver keeps
      // offering words that the block cannot take.
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        stall = 1'b1;
      end else if (!hold_done && words_out >= HOLD_AT) begin
        hold_left <= HOLD_LEN;
        hold_done <= 1'b1;
        stall = 1'b1;
      end else begin
        stall = !no_gaps && ($urandom_range(99) < 16);
      end
      rsp_if.ready <= !stall;
    end
  end

  // Watchdog: any accepted word on any channel restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      dead_cycles <= 0;
    end else if (dead_cycles == STALL_LIMIT) begin
      $display("no word accepted for %0d cycles", STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      dead_cycles <= dead_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: reset, a directed walk through the special cases, then random
  // phases, each under its own register settings.
  // ---------------------------------------------------------------------------
  initial begin
    cfg_t s;
    int   n_items;
    int   push_pct;

    rst_ni                    = 1'b0;
    req_if.valid              = 1'b0;
    req_if.operation          = '0;
    req_if.message_identifier = '0;
    req_if.length_code        = '0;
    req_if.payload            = '0;
    rsp_if.ready              = 1'b0;
    cfg_if.valid              = 1'b0;
    cfg_if.index              = '0;
    cfg_if.data               = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Out of reset the FIFO is disabled: data operations and undefined codes
    // are refused. Transmit done is kept for later, since its interrupt is
    // sticky.
    queue_op(msg_with(OP_PUSH));
    queue_op(msg_with(OP_PEEK));
    queue_op(msg_with(OP_POP));
    queue_op(msg_with(OP_UNDEF_FIRST));
    wait_idle();

    // Four entries in receive mode with the interrupt at the full level. The
    // interrupt must stay low until the fourth push, and a fifth push is lost.
    s = '0;
    s.fifo_enable       = 1'b1;
    s.depth_select      = 3'd1;
    s.threshold_eighths = THRESH_FULL;
    load_settings(s);
    queue_op('{op: OP_PUSH, ident: '1, len: LEN_MAX, payload: '1});
    queue_op('{op: OP_PUSH, ident: '0, len: '0, payload: '0});
    queue_op(msg_with(OP_PUSH));
    queue_op(msg_with(OP_TX_DONE));
    queue_op(msg_with(OP_PUSH));
    queue_op(msg_with(OP_PUSH));
    queue_op(msg_with(OP_PEEK));
    repeat (4) queue_op(msg_with(OP_POP));
    queue_op(msg_with(OP_POP));
    wait_idle();

    // Depth zero: every push is lost and the FIFO always reads as empty.
    s.depth_select = '0;
    load_settings(s);
    queue_op(msg_with(OP_PUSH));
    queue_op(msg_with(OP_PEEK));
    wait_idle();

    // Transmit mode: popping a message does not set empty, clear keeps
    // the flags, and transmit done on a disabled FIFO drops what it holds.
    s.depth_select  = 3'd1;
    s.transmit_mode = 1'b1;
    load_settings(s);
    queue_op(msg_with(OP_PUSH));
    queue_op(msg_with(OP_PUSH));
    queue_op(msg_with(OP_POP));
    queue_op(msg_with(OP_CLEAR));
    queue_op(msg_with(OP_PUSH));
    wait_idle();
    s.fifo_enable = 1'b0;
    load_settings(s);
    queue_op(msg_with(OP_TX_DONE));
    queue_op(msg_with(OP_TX_DONE));
    wait_idle();

    // Random phases. Most use small depths; one runs at the deepest setting
    // with a heavy push mix so that it fills completely. Contents are kept
    // across phases, so depth changes also hit a FIFO that holds messages.
    for (int p = 0; p < 12; p++) begin
      s.fifo_enable             = ($urandom_range(9) != 0);
      s.transmit_mode           = 1'($urandom_range(1));
      s.interrupt_every_message = 1'($urandom_range(1));
      s.threshold_eighths       = 3'($urandom_range(7));
      case ($urandom_range(9))
        0:          s.depth_select = '0;
        4, 5:       s.depth_select = 3'd2;
        6, 7:       s.depth_select = 3'd3;
        8:          s.depth_select = 3'($urandom_range(6, 4));
        default:    s.depth_select = 3'd1;
      endcase
      case ($urandom_range(2))
        0:       push_pct = 35;
        1:       push_pct = 55;
        default: push_pct = 75;
      endcase
      n_items = 41;
      if (p == 0) begin
        s.threshold_eighths = '0;
      end
      if (p == 1) begin
        s.threshold_eighths = THRESH_FULL;
      end
      if (p == 5) begin
        s.fifo_enable  = 1'b1;
        s.depth_select = DEEPEST_SEL;
        push_pct       = 92;
        n_items        = 200;
      end
      wait_idle();
      load_settings(s);
      for (int i = 0; i < n_items; i++) begin
        queue_op(random_op(push_pct));
      end
    end

    wait_idle();
    repeat (4) @(posedge clk_i);

    $display("%0d operations under %0d register settings, FIFO filled up %0d times",
             words_out, settings_used, full_hits);
    $display("answers: %0d ok, %0d refused, %0d lost, %0d empty; %0d field mismatches",
             status_seen[ST_OK], status_seen[ST_PERM], status_seen[ST_LOST],
             status_seen[ST_EMPTY], mismatches);
    if (mismatches == 0 && due_results_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
